### hdl/fha_pkg.sv
package fha_pkg;

	localparam int DATA_W = 16;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK  = 5'b00010,
		S_SPL  = 5'b00100,
		S_NXT  = 5'b01000,
		S_DONE = 5'b10000
	} st_t;

endpackage

### hdl/fha_hdr_ram.sv
module fha_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int W = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/first_fit_heap_allocator_top.sv
// First-fit heap allocator. Block headers live in a single-port-read, single-port-write
// memory indexed by byte offset; each request walks the header chain from offset 0 with
// one memory read per block visited. A split adds a second header write, and a freed
// block that has a successor reads that successor before its freed header is written.
// No clearing pass follows reset: the first header has its own reset flag.
// Only one request is in flight; a finished result sits in an output register while the
// next request is accepted.
module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES = 4096,
	parameter int HEADER_BYTES = 6,
	parameter int MIN_CHUNK = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic [fha_pkg::DATA_W-1:0] req_size,
	input  logic [fha_pkg::DATA_W-1:0] address,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fha_pkg::DATA_W-1:0] data_address,
	output logic                       ok,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import fha_pkg::*;

	localparam int OW = $clog2(HEAP_BYTES);
	localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);
	localparam logic [DATA_W:0] SPLIT_MIN = (DATA_W+1)'(HEADER_BYTES + MIN_CHUNK);
	localparam logic [DATA_W:0] HEAP_LIM = (DATA_W+1)'(HEAP_BYTES);
	localparam logic [DATA_W-1:0] SIZE0 = DATA_W'(HEAP_BYTES - HEADER_BYTES);

	typedef struct packed {
		logic [OW-1:0]     nxt;
		logic              has;
		logic [DATA_W-1:0] size;
		logic              used;
	} hdr_t;

	localparam int EW = $bits(hdr_t);

	st_t               st_q;
	logic [DATA_W-1:0] base_q;
	logic              init_q;
	logic              kind_q;
	logic [DATA_W-1:0] req_q;
	logic [DATA_W-1:0] target_q;
	logic [OW-1:0]     off_q;
	logic [OW-1:0]     prev_off_q;
	hdr_t              prev_q;
	logic              have_prev_q;
	hdr_t              b_q;
	logic [OW-1:0]     b_off_q;
	logic [OW-1:0]     nw_q;
	logic [DATA_W-1:0] res_addr_q;
	logic              res_ok_q;
	logic [OW-1:0]     rda_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_addr_q;
	logic              out_ok_q;

	logic          re;
	logic [OW-1:0] raddr;
	logic          we;
	logic [OW-1:0] waddr;
	hdr_t          wdata;
	logic [EW-1:0] ram_q;
	hdr_t          ent;

	logic              fits;
	logic [DATA_W:0]   rem;
	logic [DATA_W:0]   nw_full;
	logic              split;
	hdr_t              b_new;
	logic [OW-1:0]     b_off_new;
	logic              cfg_wr;

	fha_hdr_ram #(.DEPTH(HEAP_BYTES), .W(EW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (ram_q)
	);

	assign pready = 1'b1;
	assign prdata = {16'd0, base_q};
	assign cfg_wr = psel && penable && pwrite && !paddr[2];

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign data_address = out_addr_q;
	assign ok = out_ok_q;

	always_comb begin
		if (rda_s1 == '0 && !init_q) begin
			ent = '{nxt: '0, has: 1'b0, size: SIZE0, used: 1'b0};
		end else begin
			ent = hdr_t'(ram_q);
		end
	end

	assign fits = !ent.used && (ent.size >= req_q);
	assign rem = {1'b0, ent.size} - {1'b0, req_q};
	assign nw_full = (DATA_W+1)'(off_q) + (DATA_W+1)'(HDR) + {1'b0, req_q};
	assign split = (rem > SPLIT_MIN) && (nw_full < HEAP_LIM);

	always_comb begin
		b_new = ent;
		b_new.used = 1'b0;
		b_off_new = off_q;
		if (have_prev_q && !prev_q.used) begin
			b_new = prev_q;
			b_new.size = prev_q.size + HDR + ent.size;
			b_new.nxt = ent.nxt;
			b_new.has = ent.has;
			b_off_new = prev_off_q;
		end
	end

	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = off_q;
		wdata = ent;
		case (st_q)
			S_IDLE: begin
				re = in_valid;
			end
			S_CHK: begin
				if (kind_q == KIND_ALLOC) begin
					if (fits) begin
						we = 1'b1;
						if (split) begin
							waddr = nw_full[OW-1:0];
							wdata = '{nxt: ent.nxt, has: ent.has,
								size: rem[DATA_W-1:0] - HDR, used: 1'b0};
						end else begin
							wdata.used = 1'b1;
						end
					end else if (ent.has) begin
						re = 1'b1;
						raddr = ent.nxt;
					end
				end else begin
					if (DATA_W'(off_q) == target_q) begin
						if (b_new.has) begin
							re = 1'b1;
							raddr = b_new.nxt;
						end else begin
							we = 1'b1;
							waddr = b_off_new;
							wdata = b_new;
						end
					end else if (ent.has) begin
						re = 1'b1;
						raddr = ent.nxt;
					end
				end
			end
			S_SPL: begin
				we = 1'b1;
				waddr = off_q;
				wdata = '{nxt: nw_q, has: 1'b1, size: req_q, used: 1'b1};
			end
			S_NXT: begin
				we = 1'b1;
				waddr = b_off_q;
				wdata = b_q;
				if (!ent.used) begin
					wdata.size = b_q.size + HDR + ent.size;
					wdata.nxt = ent.nxt;
					wdata.has = ent.has;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			base_q <= '0;
			init_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				base_q <= pwdata[DATA_W-1:0];
			end
			if (we && waddr == '0) begin
				init_q <= 1'b1;
			end
			if (st_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (kind_q == KIND_ALLOC) begin
						if (fits) begin
							st_q <= split ? S_SPL : S_DONE;
						end else if (!ent.has) begin
							st_q <= S_DONE;
						end
					end else if (DATA_W'(off_q) == target_q) begin
						st_q <= b_new.has ? S_NXT : S_DONE;
					end else if (!ent.has) begin
						st_q <= S_DONE;
					end
				end
				S_SPL: begin
					st_q <= S_DONE;
				end
				S_NXT: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rda_s1 <= raddr;
		end
		case (st_q)
			S_IDLE: begin
				kind_q <= kind;
				req_q <= req_size;
				target_q <= address - base_q - HDR;
				off_q <= '0;
				have_prev_q <= 1'b0;
				res_addr_q <= '0;
				res_ok_q <= 1'b0;
			end
			S_CHK: begin
				if (kind_q == KIND_ALLOC) begin
					if (fits) begin
						nw_q <= nw_full[OW-1:0];
						res_addr_q <= base_q + DATA_W'(off_q) + HDR;
						res_ok_q <= 1'b1;
					end else if (ent.has) begin
						off_q <= ent.nxt;
					end
				end else if (DATA_W'(off_q) == target_q) begin
					b_q <= b_new;
					b_off_q <= b_off_new;
					res_ok_q <= 1'b1;
				end else if (ent.has) begin
					prev_q <= ent;
					prev_off_q <= off_q;
					have_prev_q <= 1'b1;
					off_q <= ent.nxt;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_addr_q <= res_addr_q;
					out_ok_q <= res_ok_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (st_q == S_CHK || st_q == S_SPL || st_q == S_NXT))
		else $error("header write outside a write state");

	a_split_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SPL) |-> $past(we))
		else $error("split without first header write");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (data_address == '0))
		else $error("failed item carries an address");

endmodule

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_BYTES = 4096;
	localparam int HEADER_BYTES = 6;
	localparam int MIN_CHUNK = 4;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [2:0] ADDR_HEAP_BASE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	typedef struct {
		logic [15:0] data_address;
		logic        ok;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = fha_pkg::KIND_ALLOC;
	logic [15:0] req_size = '0;
	logic [15:0] address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] data_address;
	logic        ok;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	first_fit_heap_allocator_top #(
		.HEAP_BYTES(HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MIN_CHUNK(MIN_CHUNK)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .req_size(req_size), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_address(data_address), .ok(ok),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Heap image kept by the testbench.
	logic [15:0] hp_next [HEAP_BYTES];
	logic        hp_has_next [HEAP_BYTES];
	logic [15:0] hp_size [HEAP_BYTES];
	logic        hp_used [HEAP_BYTES];
	logic [15:0] base_addr;

	alloc_result_t pending_results[$];
	int          live_blocks[$];
	int          errors = 0;
	int          mismatches = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	int          rx_hold = 0;

	task automatic merge_with_next(int off);
		int nx;
		nx = hp_next[off];
		hp_size[off] = hp_size[off] + 16'(HEADER_BYTES) + hp_size[nx];
		hp_has_next[off] = hp_has_next[nx];
		hp_next[off] = hp_next[nx];
	endtask

	task automatic heap_alloc(logic [15:0] req, output alloc_result_t r);
		int off;
		int sz;
		int nw;
		off = 0;
		r.data_address = '0;
		r.ok = 1'b0;
		for (int g = 0; g < HEAP_BYTES; g++) begin
			if (!hp_used[off] && hp_size[off] >= req) begin
				sz = hp_size[off];
				if (sz - int'(req) > HEADER_BYTES + MIN_CHUNK) begin
					nw = off + HEADER_BYTES + int'(req);
					if (nw < HEAP_BYTES) begin
						hp_next[nw] = hp_next[off];
						hp_has_next[nw] = hp_has_next[off];
						hp_size[nw] = 16'(sz - int'(req) - HEADER_BYTES);
						hp_used[nw] = 1'b0;
						hp_size[off] = req;
						hp_next[off] = 16'(nw);
						hp_has_next[off] = 1'b1;
					end
				end
				hp_used[off] = 1'b1;
				r.data_address = base_addr + 16'(off) + 16'(HEADER_BYTES);
				r.ok = 1'b1;
				live_blocks.push_back(off);
				return;
			end
			if (!hp_has_next[off]) break;
			off = hp_next[off];
		end
	endtask

	task automatic heap_free(logic [15:0] addr, output alloc_result_t r);
		logic [15:0] target;
		int off;
		int prev;
		int b;
		bit have_prev;
		target = addr - base_addr - 16'(HEADER_BYTES);
		off = 0;
		prev = 0;
		have_prev = 1'b0;
		r.data_address = '0;
		r.ok = 1'b0;
		for (int g = 0; g < HEAP_BYTES; g++) begin
			if (off == int'(target)) begin
				b = off;
				hp_used[b] = 1'b0;
				if (have_prev && !hp_used[prev]) begin
					merge_with_next(prev);
					b = prev;
				end
				if (hp_has_next[b] && !hp_used[hp_next[b]]) merge_with_next(b);
				r.ok = 1'b1;
				foreach (live_blocks[i]) if (live_blocks[i] == off) begin
					live_blocks.delete(i);
					break;
				end
				return;
			end
			if (!hp_has_next[off]) break;
			prev = off;
			have_prev = 1'b1;
			off = hp_next[off];
		end
	endtask

	task automatic send_request(logic k, logic [15:0] sz, logic [15:0] addr);
		alloc_result_t r;
		kind = k;
		req_size = sz;
		address = addr;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (k == fha_pkg::KIND_ALLOC) heap_alloc(sz, r);
		else heap_free(addr, r);
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		in_valid = 1'b0;
		repeat ($urandom_range(1, 13)) @(negedge clk);
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 4) == 0) sender_gap();
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] a, logic [31:0] v);
		drain();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = a;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (a == ADDR_HEAP_BASE) base_addr = v[15:0];
	endtask

	function automatic logic [15:0] live_addr(int idx);
		return base_addr + 16'(live_blocks[idx]) + 16'(HEADER_BYTES);
	endfunction

	task automatic free_live(int idx);
		send_request(fha_pkg::KIND_FREE, 16'($urandom), live_addr(idx));
	endtask

	task automatic test_reset_extremes();
		send_request(fha_pkg::KIND_ALLOC, 16'hFFFF, 16'hFFFF);
		send_request(fha_pkg::KIND_ALLOC, 16'd4091, 16'h0000);
		send_request(fha_pkg::KIND_ALLOC, 16'd0, 16'h0000);
		send_request(fha_pkg::KIND_FREE, 16'hFFFF, 16'h0000);
		send_request(fha_pkg::KIND_FREE, 16'h0000, 16'hFFFF);
		free_live(0);
		send_request(fha_pkg::KIND_ALLOC, 16'd4090, 16'hFFFF);
		send_request(fha_pkg::KIND_ALLOC, 16'd0, 16'h0000);
		free_live(0);
	endtask

	task automatic test_split_and_merge();
		send_request(fha_pkg::KIND_ALLOC, 16'd10, 16'h0);
		send_request(fha_pkg::KIND_ALLOC, 16'd20, 16'h0);
		send_request(fha_pkg::KIND_ALLOC, 16'd30, 16'h0);
		send_request(fha_pkg::KIND_ALLOC, 16'd40, 16'h0);
		free_live(1);
		send_request(fha_pkg::KIND_ALLOC, 16'd9, 16'h0);
		send_request(fha_pkg::KIND_ALLOC, 16'd15, 16'h0);
		free_live(0);
		free_live(0);
		send_request(fha_pkg::KIND_FREE, 16'h0, 16'(HEADER_BYTES + 2));
		send_request(fha_pkg::KIND_FREE, 16'h0, 16'(HEADER_BYTES));
		free_live(0);
		free_live(0);
		send_request(fha_pkg::KIND_ALLOC, 16'd4070, 16'h0);
		free_live(0);
	endtask

	task automatic test_base_config();
		write_reg(ADDR_HEAP_BASE, 32'h0000_FFFF);
		send_request(fha_pkg::KIND_ALLOC, 16'd12, 16'h0);
		send_request(fha_pkg::KIND_ALLOC, 16'd3, 16'h0);
		free_live(0);
		write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
		free_live(0);
		write_reg(ADDR_HEAP_BASE, 32'h0000_8000);
		send_request(fha_pkg::KIND_FREE, 16'h0, 16'h8000);
	endtask

	task automatic test_random();
		int n;
		for (int i = 0; i < 1000; i++) begin
			if (i == 400) write_reg(ADDR_HEAP_BASE, 32'($urandom));
			if (i == 700) write_reg(ADDR_HEAP_BASE, 32'h0);
			if (i == 850) begin
				drain();
				quiet = 1'b1;
			end
			if (!quiet && $urandom_range(0, 99) == 0) drain();
			maybe_gap();
			n = $urandom_range(0, 99);
			if (n < 55) send_request(fha_pkg::KIND_ALLOC, 16'($urandom_range(0, 160)),
					16'($urandom));
			else if (n < 60) send_request(fha_pkg::KIND_ALLOC, 16'($urandom),
					16'($urandom));
			else if (n < 90 && live_blocks.size() != 0)
				free_live($urandom_range(0, live_blocks.size() - 1));
			else send_request(fha_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
		end
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready = 1'b0;
			rx_hold--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready = 1'b0;
			rx_hold = $urandom_range(1, 13) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("unexpected result data_address=%h ok=%b", data_address, ok);
			end else begin
				e = pending_results.pop_front();
				if (e.data_address !== data_address || e.ok !== ok) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected data_address=%h ok=%b, got %h %b",
							e.data_address, e.ok, data_address, ok);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		base_addr = '0;
		for (int i = 0; i < HEAP_BYTES; i++) begin
			hp_next[i] = '0;
			hp_has_next[i] = 1'b0;
			hp_size[i] = '0;
			hp_used[i] = 1'b0;
		end
		hp_size[0] = 16'(HEAP_BYTES - HEADER_BYTES);
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_extremes();
		test_split_and_merge();
		test_base_config();
		test_random();
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

### filelist.f
hdl/fha_pkg.sv
hdl/fha_hdr_ram.sv
hdl/first_fit_heap_allocator_top.sv
tb/sv/tb.sv
